// ===== hw/rtl/hbra_pkg.sv =====
// Shared types, constants and tables for the boot keyboard report translator.
`timescale 1ns / 1ps
package hbra_pkg;

   localparam int SLOT_COUNT = 6;
   localparam int SLOT_IDX_W = $clog2(SLOT_COUNT);

   localparam logic [7:0] SHIFT_MASK     = 8'h22;
   localparam logic [7:0] MIN_REPORT_LEN = 8'd8;

   // Usage codes
   localparam logic [7:0] USAGE_A      = 8'h04;
   localparam logic [7:0] USAGE_Z      = 8'h1D;
   localparam logic [7:0] USAGE_1      = 8'h1E;
   localparam logic [7:0] USAGE_9      = 8'h26;
   localparam logic [7:0] USAGE_0      = 8'h27;
   localparam logic [7:0] USAGE_ENTER  = 8'h28;
   localparam logic [7:0] USAGE_BKSP   = 8'h2A;
   localparam logic [7:0] USAGE_SPACE  = 8'h2C;
   localparam logic [7:0] USAGE_MINUS  = 8'h2D;
   localparam logic [7:0] USAGE_EQUAL  = 8'h2E;
   localparam logic [7:0] USAGE_SEMI   = 8'h33;
   localparam logic [7:0] USAGE_COMMA  = 8'h36;
   localparam logic [7:0] USAGE_PERIOD = 8'h37;
   localparam logic [7:0] USAGE_SLASH  = 8'h38;

   // Shifted digit row, '1' through '9'
   localparam logic [6:0] DIGIT_SHIFT_TABLE [0:8] = '{
      7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28
   };

   typedef struct packed {
      logic [7:0] report_length;
      logic [7:0] modifier_bits;
      logic [7:0] key_slot0;
      logic [7:0] key_slot1;
      logic [7:0] key_slot2;
      logic [7:0] key_slot3;
      logic [7:0] key_slot4;
      logic [7:0] key_slot5;
   } req_type;

   typedef struct packed {
      logic [6:0] ascii_char;
      logic       last_of_report;
   } rsp_type;

   typedef struct packed {
      logic       hit;
      logic [6:0] ch;
   } lane_type;

endpackage

// ===== hw/rtl/hid_boot_report_to_ascii.sv =====
// Top level: USB HID boot keyboard report to a stream of ASCII characters.
`timescale 1ns / 1ps
// Each accepted report is translated by six lanes in parallel, one per key slot,
// and the lane results are held in a small buffer that drains one character per
// cycle, while the output is not stalled, into the output register, lowest slot
// first; the final character of a report carries last_of_report. Either shift
// bit of the modifier byte selects the shifted character set, reports shorter
// than eight bytes and empty or unmapped slots give no beat, and held keys are
// repeated on every report. Throughput is set by the single-beat result
// channel: a new report is taken in the same cycle that the last character of
// the previous one moves to the output register.
module hid_boot_report_to_ascii (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hbra_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hbra_pkg::rsp_type rsp_data
);

   logic [hbra_pkg::SLOT_COUNT-1:0][7:0]          codes;
   hbra_pkg::lane_type [hbra_pkg::SLOT_COUNT-1:0] lane_raw;
   hbra_pkg::lane_type [hbra_pkg::SLOT_COUNT-1:0] lanes;
   logic                                          shift;
   logic                                          long_enough;
   logic                                          can_load;
   logic                                          accept;

   assign shift       = (req_data.modifier_bits & hbra_pkg::SHIFT_MASK) != 8'd0;
   assign long_enough = req_data.report_length >= hbra_pkg::MIN_REPORT_LEN;

   assign codes[0] = req_data.key_slot0;
   assign codes[1] = req_data.key_slot1;
   assign codes[2] = req_data.key_slot2;
   assign codes[3] = req_data.key_slot3;
   assign codes[4] = req_data.key_slot4;
   assign codes[5] = req_data.key_slot5;

   // One lane per key slot; drop every hit of a short report
   for (genvar g = 0; g < hbra_pkg::SLOT_COUNT; g++) begin : g_lane
      hbra_lane u_lane (
         .code  (codes[g]),
         .shift (shift),
         .lane  (lane_raw[g])
      );
      assign lanes[g].hit = lane_raw[g].hit && long_enough;
      assign lanes[g].ch  = lane_raw[g].ch;
   end

   // Hold off a new report until the buffer frees up
   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;

   hbra_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .lanes     (lanes),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/hbra_lane.sv =====
// One translation lane: usage code and shift state to an ASCII character.
`timescale 1ns / 1ps
module hbra_lane (
   input  logic [7:0]         code,
   input  logic               shift,
   output hbra_pkg::lane_type lane
);

   logic [6:0] letter_off;
   logic [3:0] digit_off;

   assign letter_off = 7'(code - hbra_pkg::USAGE_A);
   assign digit_off  = 4'(code - hbra_pkg::USAGE_1);

   always_comb begin
      lane.hit = 1'b1;
      lane.ch  = 7'd0;
      unique case (code) inside
         [hbra_pkg::USAGE_A:hbra_pkg::USAGE_Z]: begin
            lane.ch = (shift ? 7'h41 : 7'h61) + letter_off;
         end
         [hbra_pkg::USAGE_1:hbra_pkg::USAGE_9]: begin
            lane.ch = shift ? hbra_pkg::DIGIT_SHIFT_TABLE[digit_off]
                            : 7'h31 + {3'd0, digit_off};
         end
         hbra_pkg::USAGE_0:      lane.ch = shift ? 7'h29 : 7'h30;
         hbra_pkg::USAGE_ENTER:  lane.ch = 7'h0A;
         hbra_pkg::USAGE_BKSP:   lane.ch = 7'h08;
         hbra_pkg::USAGE_SPACE:  lane.ch = 7'h20;
         hbra_pkg::USAGE_MINUS:  lane.ch = shift ? 7'h5F : 7'h2D;
         hbra_pkg::USAGE_EQUAL:  lane.ch = shift ? 7'h2B : 7'h3D;
         hbra_pkg::USAGE_SEMI:   lane.ch = shift ? 7'h3A : 7'h3B;
         hbra_pkg::USAGE_COMMA:  lane.ch = shift ? 7'h3C : 7'h2C;
         hbra_pkg::USAGE_PERIOD: lane.ch = shift ? 7'h3E : 7'h2E;
         hbra_pkg::USAGE_SLASH:  lane.ch = shift ? 7'h3F : 7'h2F;
         default:                lane.hit = 1'b0;
      endcase
   end

endmodule

// ===== hw/rtl/hbra_emit.sv =====
// Merge stage: hold one report's lane results, drain a beat a cycle unless stalled.
`timescale 1ns / 1ps
module hbra_emit (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           load,
   input  hbra_pkg::lane_type [hbra_pkg::SLOT_COUNT-1:0]  lanes,
   output logic                                           can_load,
   output logic                                           rsp_valid,
   input  logic                                           rsp_stall,
   output hbra_pkg::rsp_type                              rsp_data
);

   logic [hbra_pkg::SLOT_COUNT-1:0] mask_ff, mask_in;
   logic [hbra_pkg::SLOT_COUNT-1:0][6:0] char_ff, char_in;
   logic [hbra_pkg::SLOT_COUNT-1:0] rest;
   logic [hbra_pkg::SLOT_IDX_W-1:0] sel;
   logic                            out_free;
   logic                            pop;
   logic                            rsp_valid_ff, rsp_valid_in;
   hbra_pkg::rsp_type               rsp_ff, rsp_in;

   // Lowest pending slot goes first
   always_comb begin
      sel = '0;
      for (int i = hbra_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = hbra_pkg::SLOT_IDX_W'(i);
         end
      end
   end

   assign rest     = mask_ff & (mask_ff - 1'b1);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (|mask_ff) && out_free;
   assign can_load = (mask_ff == '0) || (pop && (rest == '0));

   always_comb begin
      mask_in = mask_ff;
      char_in = char_ff;
      if (load) begin
         for (int i = 0; i < hbra_pkg::SLOT_COUNT; i++) begin
            mask_in[i] = lanes[i].hit;
            char_in[i] = lanes[i].ch;
         end
      end else if (pop) begin
         mask_in = rest;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pop) begin
         rsp_valid_in          = 1'b1;
         rsp_in.ascii_char     = char_ff[sel];
         rsp_in.last_of_report = (rest == '0);
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sim/hid_boot_report_to_ascii_tb.sv =====
// Self-checking bench for the boot keyboard report to ASCII translator.
`timescale 1ns / 1ps
module hid_boot_report_to_ascii_tb;

   localparam logic [6:0] CHAR_LF = 7'h0A;
   localparam logic [6:0] CHAR_BS = 7'h08;
   localparam int MAX_SHOWN = 10;

   // Work out the characters a report must give and hold them in arrival order.
   class char_scoreboard;
      hbra_pkg::rsp_type pending[$];
      int                failures;

      // Map one usage code to its character; zero means the slot gives no beat.
      function logic [6:0] usage_char(logic [7:0] code, bit shifted);
         string digit_syms = "!@#$%^&*(";
         if (code >= hbra_pkg::USAGE_A && code <= hbra_pkg::USAGE_Z)
            return (shifted ? 7'("A") : 7'("a")) + 7'(code - hbra_pkg::USAGE_A);
         if (code >= hbra_pkg::USAGE_1 && code <= hbra_pkg::USAGE_9)
            return shifted ? 7'(digit_syms[code - hbra_pkg::USAGE_1])
                           : 7'("1") + 7'(code - hbra_pkg::USAGE_1);
         case (code)
            hbra_pkg::USAGE_0:      return shifted ? 7'(")") : 7'("0");
            hbra_pkg::USAGE_ENTER:  return CHAR_LF;
            hbra_pkg::USAGE_BKSP:   return CHAR_BS;
            hbra_pkg::USAGE_SPACE:  return 7'(" ");
            hbra_pkg::USAGE_MINUS:  return shifted ? 7'("_") : 7'("-");
            hbra_pkg::USAGE_EQUAL:  return shifted ? 7'("+") : 7'("=");
            hbra_pkg::USAGE_SEMI:   return shifted ? 7'(":") : 7'(";");
            hbra_pkg::USAGE_COMMA:  return shifted ? 7'("<") : 7'(",");
            hbra_pkg::USAGE_PERIOD: return shifted ? 7'(">") : 7'(".");
            hbra_pkg::USAGE_SLASH:  return shifted ? 7'("?") : 7'("/");
            default:                return 7'd0;
         endcase
      endfunction

      function void note_report(hbra_pkg::req_type r);
         logic [7:0]        codes [hbra_pkg::SLOT_COUNT];
         hbra_pkg::rsp_type chars[$];
         hbra_pkg::rsp_type one;
         bit                shifted;
         logic [6:0]        ch;
         codes = '{r.key_slot0, r.key_slot1, r.key_slot2,
                   r.key_slot3, r.key_slot4, r.key_slot5};
         shifted = |(r.modifier_bits & hbra_pkg::SHIFT_MASK);
         // short reports give nothing at all
         if (r.report_length < hbra_pkg::MIN_REPORT_LEN)
            return;
         foreach (codes[i]) begin
            ch = usage_char(codes[i], shifted);
            if (ch != 7'd0) begin
               one.ascii_char     = ch;
               one.last_of_report = 1'b0;
               chars.push_back(one);
            end
         end
         if (chars.size() > 0)
            chars[chars.size() - 1].last_of_report = 1'b1;
         foreach (chars[i])
            pending.push_back(chars[i]);
      endfunction

      function void check_char(hbra_pkg::rsp_type got);
         hbra_pkg::rsp_type want;
         if (pending.size() == 0) begin
            failures++;
            if (failures <= MAX_SHOWN)
               $display("%0t: unexpected char beat %h last %b", $realtime,
                        got.ascii_char, got.last_of_report);
            return;
         end
         want = pending.pop_front();
         if (got.ascii_char !== want.ascii_char
             || got.last_of_report !== want.last_of_report) begin
            failures++;
            if (failures <= MAX_SHOWN)
               $display("%0t: char mismatch: expected %h last %b, got %h last %b",
                        $realtime, want.ascii_char, want.last_of_report,
                        got.ascii_char, got.last_of_report);
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   hbra_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   hbra_pkg::rsp_type rsp_data;

   char_scoreboard board = new;

   // Idling odds for the current phase, in percent.
   int send_idle_pct = 0;
   int stall_pct     = 0;

   hid_boot_report_to_ascii i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe both channels at the edge; everything read here is the pre-edge
   // value the block itself saw, so acceptance is judged exactly as it is.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_report(req_data);
         if (rsp_valid && !rsp_stall)
            board.check_char(rsp_data);
      end
   end

   // Drive the result-side stall. Early on, hold off for a long stretch while
   // the sender keeps offering, so the block fills up and pushes back on its
   // input; otherwise stall at the phase's random rate.
   initial begin
      int cycles_out_of_reset;
      int hold_left;
      cycles_out_of_reset = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_stall <= 1'b0;
         end else begin
            cycles_out_of_reset++;
            if (cycles_out_of_reset == 40)
               hold_left = 400;
            if (hold_left > 0) begin
               rsp_stall <= 1'b1;
               hold_left--;
            end else begin
               rsp_stall <= ($urandom_range(99) < stall_pct);
            end
         end
      end
   end

   function automatic hbra_pkg::req_type make_report(logic [7:0] len, logic [7:0] mods,
                                                     logic [7:0] s0, logic [7:0] s1,
                                                     logic [7:0] s2, logic [7:0] s3,
                                                     logic [7:0] s4, logic [7:0] s5);
      hbra_pkg::req_type r;
      r.report_length = len;
      r.modifier_bits = mods;
      r.key_slot0 = s0;
      r.key_slot1 = s1;
      r.key_slot2 = s2;
      r.key_slot3 = s3;
      r.key_slot4 = s4;
      r.key_slot5 = s5;
      return r;
   endfunction

   function automatic logic [7:0] random_slot();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60)
         return 8'($urandom_range(hbra_pkg::USAGE_A, hbra_pkg::USAGE_SLASH));
      if (pick < 85)
         return 8'd0;
      return 8'($urandom);
   endfunction

   // Mostly well-formed reports with random keys; the rest is pure noise.
   function automatic hbra_pkg::req_type random_report();
      hbra_pkg::req_type r;
      int                pick;
      logic [7:0]        shift_choices [4];
      shift_choices = '{8'h00, 8'h02, 8'h20, 8'h22};
      if ($urandom_range(99) < 15) begin
         r = hbra_pkg::req_type'({$urandom, $urandom});
         return r;
      end
      pick = $urandom_range(99);
      if (pick < 75)
         r.report_length = hbra_pkg::MIN_REPORT_LEN;
      else if (pick < 95)
         r.report_length = 8'($urandom_range(9, 255));
      else
         r.report_length = 8'($urandom_range(0, 7));
      r.modifier_bits = $urandom_range(1) ? 8'($urandom) : shift_choices[$urandom_range(3)];
      r.key_slot0 = random_slot();
      r.key_slot1 = random_slot();
      r.key_slot2 = random_slot();
      r.key_slot3 = random_slot();
      r.key_slot4 = random_slot();
      r.key_slot5 = random_slot();
      return r;
   endfunction

   // Offer one report and return at the edge that accepts it. Valid stays high
   // into the next call unless that call starts with an idle gap.
   task automatic send_report(input hbra_pkg::req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct)
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drop valid and wait until every expected character has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_directed();
      // every letter, plain and with either shift key
      send_report(make_report(8'd8, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_report(make_report(8'd8, 8'h02, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
      send_report(make_report(8'd8, 8'h20, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15));
      send_report(make_report(8'd8, 8'h22, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h1B));
      // letter row end and the digit row, both ways
      send_report(make_report(8'd8, 8'h00, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21));
      send_report(make_report(8'd8, 8'h02, 8'h1C, 8'h1D, 8'h1E, 8'h1F, 8'h20, 8'h21));
      send_report(make_report(8'd8, 8'h00, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27));
      send_report(make_report(8'd8, 8'h20, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27));
      // control keys and punctuation
      send_report(make_report(8'd8, 8'h00, 8'h28, 8'h2A, 8'h2C, 8'h2D, 8'h2E, 8'h33));
      send_report(make_report(8'd8, 8'h02, 8'h28, 8'h2A, 8'h2C, 8'h2D, 8'h2E, 8'h33));
      send_report(make_report(8'd8, 8'h00, 8'h36, 8'h37, 8'h38, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'd8, 8'h20, 8'h36, 8'h37, 8'h38, 8'h00, 8'h04, 8'h00));
      // short reports: nothing comes out whatever the slots hold
      send_report(make_report(8'd7, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_report(make_report(8'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      // long reports, and modifiers other than shift that must be ignored
      send_report(make_report(8'd255, 8'hDD, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      send_report(make_report(8'd9, 8'hFF, 8'h04, 8'h1E, 8'h27, 8'h2D, 8'h38, 8'h28));
      // empty and unmapped slots
      send_report(make_report(8'd8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_report(make_report(8'd8, 8'h00, 8'h01, 8'h02, 8'h03, 8'h29, 8'h2B, 8'hFF));
      send_report(make_report(8'd8, 8'h22, 8'h00, 8'h2F, 8'h04, 8'h34, 8'h00, 8'h39));
      send_report(make_report(8'd128, 8'h00, 8'h35, 8'h3A, 8'h80, 8'h00, 8'h00, 8'h1D));
      send_report(make_report(8'd8, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
   endtask

   initial begin
      int idle_odds  [4];
      int stall_odds [4];
      int per_phase  [4];
      idle_odds  = '{0, 84, 0, 11};
      stall_odds = '{0, 0, 84, 11};
      per_phase  = '{90, 107, 107, 107};
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Change the idling odds only while both channels are quiet.
      foreach (per_phase[p]) begin
         send_idle_pct = idle_odds[p];
         stall_pct     = stall_odds[p];
         if (p == 0)
            send_directed();
         repeat (per_phase[p])
            send_report(random_report());
         drain();
      end

      // Let the clock run on so any stray beat is caught.
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/hbra_pkg.sv
hw/rtl/hbra_lane.sv
hw/rtl/hbra_emit.sv
hw/rtl/hid_boot_report_to_ascii.sv
sim/hid_boot_report_to_ascii_tb.sv
